>>> sv/tlfqs_pkg.sv
// Types and constants shared by the three-level feedback queue scheduler.
// Holds the operation codes, the packed per-slot record and the fixed quanta.
// No dependencies.
package tlfqs_pkg;

   typedef enum logic [2:0] {
      OP_CREATE  = 3'd0,
      OP_PICK    = 3'd1,
      OP_TICK    = 3'd2,
      OP_YIELD   = 3'd3,
      OP_RELEASE = 3'd4,
      OP_WAKE    = 3'd5,
      OP_SETPRI  = 3'd6,
      OP_BOOST   = 3'd7
   } op_type;

   typedef struct packed {
      logic [1:0] prio;
      logic [3:0] quantum;
      logic [1:0] level;
   } info_type;

   localparam int INFO_W = 8;

   localparam logic [3:0] NEW_QUANTUM = 4'd4;
   localparam logic [3:0] L1_QUANTUM  = 4'd6;
   localparam logic [3:0] L2_QUANTUM  = 4'd8;
   localparam logic [1:0] NEW_PRIO    = 2'd3;
   localparam logic [1:0] LVL_TOP     = 2'd2;
   localparam logic [1:0] LVL_NONE    = 2'd3;

endpackage

>>> sv/three_level_feedback_queue_scheduler.sv
// Three-level feedback queue scheduler: top level with the sequencer and queue registers.
// Depends on tlfqs_pkg and tlfqs_ram (slot records and queue links).
//
//   channel | dir | beat contents
//   req     | in  | tdata: operation, process, new_priority
//   rsp     | out | tdata: chosen_process, chosen_level; tuser: valid_res
//
// Every request is paced by the one read port of each RAM. Insertion into the sorted
// top level walks the links through S_PUT_CHK, S_PUT_NX and S_PUT_NP per slot passed,
// a priority update scans the queues through S_SP_SCAN and S_SP_NEXT per slot, and boost
// visits each slot already in level 0 in S_BST_L0 and moves each slot up through
// S_BST_POP, S_BST_POPN (skipped for the last slot of a level) and S_PUT.
// Reset is synchronous; a response waiting on the output register does not hold off
// the next request, which waits in S_FINISH only while that response is not taken.
module three_level_feedback_queue_scheduler
   import tlfqs_pkg::*;
#(
   parameter int NUM_PROCS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // operation[2:0], process[8:3], new_priority[10:9]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // chosen_process[5:0], chosen_level[7:6]
   output logic        rsp_tuser    // valid_res
);

   localparam int PW = $clog2(NUM_PROCS);
   localparam int SW = $clog2(NUM_PROCS + 1);
   localparam logic [SW-1:0] STEP_MAX = SW'(NUM_PROCS);

   typedef enum logic [4:0] {
      S_IDLE, S_PICK, S_TICK, S_YIELD, S_WAKE, S_SP_RUN, S_SP_LVL, S_SP_SCAN,
      S_SP_NEXT, S_SP_HIT, S_SP_UNLINK, S_BST_L0, S_BST_POP, S_BST_POPN,
      S_BST_RUN, S_PUT, S_PUT_H, S_PUT_CHK, S_PUT_NX, S_PUT_NP, S_PUT_LINK1,
      S_PUT_LINK2, S_FINISH
   } state_type;

   state_type       state_ff, state_in;
   logic [PW-1:0]   head_ff [3];
   logic [PW-1:0]   head_in [3];
   logic [PW-1:0]   tail_ff [3];
   logic [PW-1:0]   tail_in [3];
   logic [2:0]      nonempty_ff, nonempty_in;
   logic [PW-1:0]   run_ff, run_in;
   logic            run_vld_ff, run_vld_in;
   logic [PW-1:0]   s_ff, s_in;
   logic [1:0]      pr_ff, pr_in;
   logic [1:0]      lvl_ff, lvl_in;
   logic [PW-1:0]   cur_ff, cur_in;
   logic [PW-1:0]   prev_ff, prev_in;
   logic [PW-1:0]   nxt_ff, nxt_in;
   logic [SW-1:0]   steps_ff, steps_in;
   logic            first_ff, first_in;
   logic [PW-1:0]   put_s_ff, put_s_in;
   logic [1:0]      put_lvl_ff, put_lvl_in;
   logic [1:0]      put_p_ff, put_p_in;
   logic            ret_bst_ff, ret_bst_in;
   logic            vres_ff, vres_in;
   logic [1:0]      lres_ff, lres_in;
   logic            rsp_vld_ff, rsp_vld_in;
   logic [7:0]      rsp_data_ff, rsp_data_in;
   logic            rsp_user_ff, rsp_user_in;
   logic [NUM_PROCS-1:0] ivld_ff, ivld_in;
   logic            rvld_ff, rvld_in;

   logic            iw_en, nw_en;
   logic [PW-1:0]   iw_addr, nw_addr, ir_addr, nr_addr;
   info_type        iw_data, ir_raw, info_rd;
   logic [PW-1:0]   nw_data, next_rd;

   op_type          req_op;
   logic [PW-1:0]   req_s;
   logic            req_ok, pick_hit;
   logic [1:0]      pick_lvl, lvl_c;

   tlfqs_ram #(.WIDTH(INFO_W), .DEPTH(NUM_PROCS)) u_info (
      .clock(clock), .we(iw_en), .waddr(iw_addr), .wdata(iw_data),
      .raddr(ir_addr), .rdata(ir_raw)
   );

   tlfqs_ram #(.WIDTH(PW), .DEPTH(NUM_PROCS)) u_link (
      .clock(clock), .we(nw_en), .waddr(nw_addr), .wdata(nw_data),
      .raddr(nr_addr), .rdata(next_rd)
   );

   assign info_rd    = rvld_ff ? ir_raw : info_type'('0);
   assign lvl_c      = (info_rd.level == LVL_NONE) ? LVL_TOP : info_rd.level;
   assign req_op     = op_type'(req_tdata[2:0]);
   assign req_s      = PW'(req_tdata[8:3]);
   assign req_ok     = 32'(req_tdata[8:3]) < 32'(NUM_PROCS);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      pick_hit = 1'b1;
      pick_lvl = 2'd0;
      if (nonempty_ff[0]) begin
         pick_lvl = 2'd0;
      end else if (nonempty_ff[1]) begin
         pick_lvl = 2'd1;
      end else if (nonempty_ff[2]) begin
         pick_lvl = 2'd2;
      end else begin
         pick_hit = 1'b0;
      end
   end

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      nonempty_in = nonempty_ff;
      run_in      = run_ff;
      run_vld_in  = run_vld_ff;
      s_in        = s_ff;
      pr_in       = pr_ff;
      lvl_in      = lvl_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      nxt_in      = nxt_ff;
      steps_in    = steps_ff;
      first_in    = first_ff;
      put_s_in    = put_s_ff;
      put_lvl_in  = put_lvl_ff;
      put_p_in    = put_p_ff;
      ret_bst_in  = ret_bst_ff;
      vres_in     = vres_ff;
      lres_in     = lres_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      iw_en       = 1'b0;
      iw_addr     = cur_ff;
      iw_data     = info_rd;
      nw_en       = 1'b0;
      nw_addr     = cur_ff;
      nw_data     = put_s_ff;
      ir_addr     = cur_ff;
      nr_addr     = cur_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               s_in       = req_s;
               pr_in      = req_tdata[10:9];
               vres_in    = 1'b0;
               lres_in    = 2'd0;
               ret_bst_in = 1'b0;
               state_in   = S_FINISH;
               unique case (req_op)
                  OP_CREATE: begin
                     if (req_ok) begin
                        iw_en      = 1'b1;
                        iw_addr    = req_s;
                        iw_data    = '{prio: NEW_PRIO, quantum: NEW_QUANTUM, level: 2'd0};
                        put_s_in   = req_s;
                        put_lvl_in = 2'd0;
                        put_p_in   = NEW_PRIO;
                        state_in   = S_PUT;
                     end
                  end
                  OP_PICK: begin
                     if (pick_hit) begin
                        vres_in    = 1'b1;
                        lres_in    = pick_lvl;
                        lvl_in     = pick_lvl;
                        run_in     = head_ff[pick_lvl];
                        run_vld_in = 1'b1;
                        if (head_ff[pick_lvl] == tail_ff[pick_lvl]) begin
                           nonempty_in[pick_lvl] = 1'b0;
                        end else begin
                           nr_addr  = head_ff[pick_lvl];
                           state_in = S_PICK;
                        end
                     end
                  end
                  OP_TICK: begin
                     if (run_vld_ff) begin
                        ir_addr  = run_ff;
                        state_in = S_TICK;
                     end
                  end
                  OP_YIELD: begin
                     if (run_vld_ff) begin
                        ir_addr  = run_ff;
                        state_in = S_YIELD;
                     end
                  end
                  OP_RELEASE: begin
                     run_vld_in = 1'b0;
                  end
                  OP_WAKE: begin
                     if (req_ok) begin
                        ir_addr  = req_s;
                        state_in = S_WAKE;
                     end
                  end
                  OP_SETPRI: begin
                     if (req_ok) begin
                        if (run_vld_ff && run_ff == req_s) begin
                           ir_addr  = req_s;
                           state_in = S_SP_RUN;
                        end else begin
                           lvl_in   = 2'd0;
                           state_in = S_SP_LVL;
                        end
                     end
                  end
                  OP_BOOST: begin
                     steps_in = '0;
                     if (nonempty_ff[0]) begin
                        cur_in   = head_ff[0];
                        ir_addr  = head_ff[0];
                        nr_addr  = head_ff[0];
                        state_in = S_BST_L0;
                     end else begin
                        lvl_in   = 2'd1;
                        state_in = S_BST_POP;
                     end
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_PICK: begin
            head_in[lvl_ff] = next_rd;
            state_in        = S_FINISH;
         end
         S_TICK: begin
            iw_en   = 1'b1;
            iw_addr = run_ff;
            iw_data = info_rd;
            if (info_rd.quantum != 4'd0) begin
               iw_data.quantum = 4'(info_rd.quantum - 4'd1);
            end
            state_in = S_FINISH;
         end
         S_YIELD: begin
            run_vld_in = 1'b0;
            iw_en      = 1'b1;
            iw_addr    = run_ff;
            put_s_in   = run_ff;
            iw_data    = info_rd;
            if (info_rd.quantum == 4'd0) begin
               if (lvl_c == LVL_TOP) begin
                  iw_data.prio    = (info_rd.prio != 2'd0) ? 2'(info_rd.prio - 2'd1) : 2'd0;
                  iw_data.quantum = L2_QUANTUM;
                  iw_data.level   = LVL_TOP;
               end else begin
                  iw_data.quantum = (lvl_c == 2'd0) ? L1_QUANTUM : L2_QUANTUM;
                  iw_data.level   = 2'(lvl_c + 2'd1);
               end
            end else begin
               iw_data.level = lvl_c;
            end
            put_lvl_in = iw_data.level;
            put_p_in   = iw_data.prio;
            state_in   = S_PUT;
         end
         S_WAKE: begin
            iw_en         = 1'b1;
            iw_addr       = s_ff;
            iw_data       = info_rd;
            iw_data.level = lvl_c;
            put_s_in      = s_ff;
            put_lvl_in    = lvl_c;
            put_p_in      = info_rd.prio;
            state_in      = S_PUT;
         end
         S_SP_RUN: begin
            iw_en        = 1'b1;
            iw_addr      = s_ff;
            iw_data      = info_rd;
            iw_data.prio = pr_ff;
            vres_in      = 1'b1;
            state_in     = S_FINISH;
         end
         S_SP_LVL: begin
            if (lvl_ff == LVL_NONE) begin
               state_in = S_FINISH;
            end else if (!nonempty_ff[lvl_ff]) begin
               lvl_in = 2'(lvl_ff + 2'd1);
            end else begin
               cur_in   = head_ff[lvl_ff];
               first_in = 1'b1;
               steps_in = '0;
               state_in = S_SP_SCAN;
            end
         end
         S_SP_SCAN: begin
            if (cur_ff == s_ff) begin
               ir_addr  = s_ff;
               state_in = S_SP_HIT;
            end else if (cur_ff == tail_ff[lvl_ff] || steps_ff >= STEP_MAX) begin
               lvl_in   = 2'(lvl_ff + 2'd1);
               state_in = S_SP_LVL;
            end else begin
               prev_in  = cur_ff;
               nr_addr  = cur_ff;
               first_in = 1'b0;
               steps_in = SW'(steps_ff + SW'(1));
               state_in = S_SP_NEXT;
            end
         end
         S_SP_NEXT: begin
            cur_in   = next_rd;
            state_in = S_SP_SCAN;
         end
         S_SP_HIT: begin
            iw_en        = 1'b1;
            iw_addr      = s_ff;
            iw_data      = info_rd;
            iw_data.prio = pr_ff;
            vres_in      = 1'b1;
            if (lvl_ff == LVL_TOP) begin
               iw_data.level = LVL_TOP;
               nr_addr       = cur_ff;
               state_in      = S_SP_UNLINK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SP_UNLINK: begin
            if (first_ff) begin
               if (cur_ff == tail_ff[2]) begin
                  nonempty_in[2] = 1'b0;
               end else begin
                  head_in[2] = next_rd;
               end
            end else begin
               nw_en   = 1'b1;
               nw_addr = prev_ff;
               nw_data = next_rd;
               if (cur_ff == tail_ff[2]) begin
                  tail_in[2] = prev_ff;
               end
            end
            put_s_in   = s_ff;
            put_lvl_in = LVL_TOP;
            put_p_in   = pr_ff;
            state_in   = S_PUT;
         end
         S_BST_L0: begin
            iw_en           = 1'b1;
            iw_addr         = cur_ff;
            iw_data         = info_rd;
            iw_data.quantum = NEW_QUANTUM;
            if (cur_ff == tail_ff[0] || steps_ff >= STEP_MAX) begin
               lvl_in   = 2'd1;
               steps_in = '0;
               state_in = S_BST_POP;
            end else begin
               cur_in   = next_rd;
               ir_addr  = next_rd;
               nr_addr  = next_rd;
               steps_in = SW'(steps_ff + SW'(1));
            end
         end
         S_BST_POP: begin
            if (lvl_ff == LVL_NONE) begin
               state_in = run_vld_ff ? S_BST_RUN : S_FINISH;
            end else if (steps_ff >= STEP_MAX || !nonempty_ff[lvl_ff]) begin
               lvl_in   = 2'(lvl_ff + 2'd1);
               steps_in = '0;
            end else begin
               cur_in     = head_ff[lvl_ff];
               iw_en      = 1'b1;
               iw_addr    = head_ff[lvl_ff];
               iw_data    = '{prio: NEW_PRIO, quantum: NEW_QUANTUM, level: 2'd0};
               steps_in   = SW'(steps_ff + SW'(1));
               put_s_in   = head_ff[lvl_ff];
               put_lvl_in = 2'd0;
               put_p_in   = NEW_PRIO;
               ret_bst_in = 1'b1;
               if (head_ff[lvl_ff] == tail_ff[lvl_ff]) begin
                  nonempty_in[lvl_ff] = 1'b0;
                  state_in            = S_PUT;
               end else begin
                  nr_addr  = head_ff[lvl_ff];
                  state_in = S_BST_POPN;
               end
            end
         end
         S_BST_POPN: begin
            head_in[lvl_ff] = next_rd;
            state_in        = S_PUT;
         end
         S_BST_RUN: begin
            iw_en    = 1'b1;
            iw_addr  = run_ff;
            iw_data  = '{prio: NEW_PRIO, quantum: NEW_QUANTUM, level: 2'd0};
            state_in = S_FINISH;
         end
         S_PUT: begin
            if (!nonempty_ff[put_lvl_ff]) begin
               head_in[put_lvl_ff]     = put_s_ff;
               tail_in[put_lvl_ff]     = put_s_ff;
               nonempty_in[put_lvl_ff] = 1'b1;
               state_in = ret_bst_ff ? S_BST_POP : S_FINISH;
            end else if (put_lvl_ff != LVL_TOP) begin
               nw_en   = 1'b1;
               nw_addr = tail_ff[put_lvl_ff];
               nw_data = put_s_ff;
               tail_in[put_lvl_ff] = put_s_ff;
               state_in = ret_bst_ff ? S_BST_POP : S_FINISH;
            end else begin
               cur_in   = head_ff[2];
               ir_addr  = head_ff[2];
               steps_in = '0;
               state_in = S_PUT_H;
            end
         end
         S_PUT_H: begin
            if (put_p_ff < info_rd.prio) begin
               nw_en      = 1'b1;
               nw_addr    = put_s_ff;
               nw_data    = head_ff[2];
               head_in[2] = put_s_ff;
               state_in   = S_FINISH;
            end else begin
               state_in = S_PUT_CHK;
            end
         end
         S_PUT_CHK: begin
            if (cur_ff == tail_ff[2]) begin
               nw_en      = 1'b1;
               nw_addr    = cur_ff;
               nw_data    = put_s_ff;
               tail_in[2] = put_s_ff;
               state_in   = S_FINISH;
            end else begin
               nr_addr  = cur_ff;
               state_in = (steps_ff >= STEP_MAX) ? S_PUT_LINK1 : S_PUT_NX;
            end
         end
         S_PUT_NX: begin
            nxt_in   = next_rd;
            ir_addr  = next_rd;
            state_in = S_PUT_NP;
         end
         S_PUT_NP: begin
            if (info_rd.prio <= put_p_ff) begin
               cur_in   = nxt_ff;
               steps_in = SW'(steps_ff + SW'(1));
               state_in = S_PUT_CHK;
            end else begin
               nw_en    = 1'b1;
               nw_addr  = put_s_ff;
               nw_data  = nxt_ff;
               state_in = S_PUT_LINK2;
            end
         end
         S_PUT_LINK1: begin
            nw_en    = 1'b1;
            nw_addr  = put_s_ff;
            nw_data  = next_rd;
            state_in = S_PUT_LINK2;
         end
         S_PUT_LINK2: begin
            nw_en    = 1'b1;
            nw_addr  = cur_ff;
            nw_data  = put_s_ff;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {lres_ff, 6'(run_ff)};
               rsp_user_in = vres_ff;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      ivld_in = ivld_ff;
      if (iw_en) begin
         ivld_in[iw_addr] = 1'b1;
      end
      rvld_in = ivld_ff[ir_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         nonempty_ff <= '0;
         run_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         ivld_ff     <= '0;
         rvld_ff     <= 1'b0;
         run_ff      <= '0;
         for (int i = 0; i < 3; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         nonempty_ff <= nonempty_in;
         run_vld_ff  <= run_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         ivld_ff     <= ivld_in;
         rvld_ff     <= rvld_in;
         run_ff      <= run_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
      end
      s_ff        <= s_in;
      pr_ff       <= pr_in;
      lvl_ff      <= lvl_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      nxt_ff      <= nxt_in;
      steps_ff    <= steps_in;
      first_ff    <= first_in;
      put_s_ff    <= put_s_in;
      put_lvl_ff  <= put_lvl_in;
      put_p_ff    <= put_p_in;
      ret_bst_ff  <= ret_bst_in;
      vres_ff     <= vres_in;
      lres_ff     <= lres_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

>>> sv/tlfqs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-slot records and the queue links. No dependencies.
module tlfqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
